[src/wdld_pkg.sv]
// Shared types, constants and state codes for the window label density block.
package wdld_pkg;

    localparam int WINDOW_SIDE_DEF = 70;
    localparam int LABEL_BITS_DEF  = 16;

    localparam int IN_LABEL_W = 16;
    localparam int STAGE_W    = 2;
    localparam int COUNT_W    = 13;
    localparam int SUM_W      = COUNT_W + 1;
    localparam int FRAC_W     = 16;
    localparam int DIVIDEND_W = SUM_W + FRAC_W;
    localparam int DENSITY_W  = 20;

    localparam logic [STAGE_W-1:0] STAGE_SMALL = 2'd2;

    localparam int EPOCH_W    = 8;
    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [IN_LABEL_W-1:0] pixel_label;
        logic [STAGE_W-1:0]    pixel_stage;
        logic                  center_stage_zero;
        logic                  last_pixel;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0]   distinct_cells;
        logic [COUNT_W-1:0]   small_pixels;
        logic [DENSITY_W-1:0] density_q16;
    } t_out;

    typedef struct packed {
        logic is_small;
        logic quarter;
        logic last;
    } t_work_ctl;

    typedef struct packed {
        logic [COUNT_W-1:0] distinct_cnt;
        logic [COUNT_W-1:0] small_cnt;
        logic               quarter;
    } t_job;

    typedef struct packed {
        logic sweeping;
        logic issue;
    } t_back_stat;

    typedef enum logic {
        BK_SWEEP,
        BK_RUN
    } t_back_state;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_MUL,
        DV_CHK,
        DV_FIX,
        DV_DONE
    } t_div_state;

endpackage

[src/wdld_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module wdld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/wdld_front.sv]
// Front end: accepts pixel beats, classifies them and queues them for the back end.
module wdld_front #(
    parameter int LABEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  wdld_pkg::t_in         i_in,
    output logic                  o_wk_valid,
    input  logic                  i_wk_ready,
    output logic [LABEL_BITS-1:0] o_wk_label,
    output wdld_pkg::t_work_ctl   o_wk_ctl
);

    import wdld_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [LABEL_BITS-1:0] r_lbl [FIFO_DEPTH];
    t_work_ctl             r_ctl [FIFO_DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]      r_count, n_count;

    logic      push, pop;
    t_work_ctl in_ctl;

    always_comb begin
        in_ctl.is_small = (i_in.pixel_stage == STAGE_SMALL);
        in_ctl.quarter  = i_in.center_stage_zero;
        in_ctl.last     = i_in.last_pixel;
    end

    assign o_in_ready = (r_count != CNT_W'(FIFO_DEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign o_wk_valid = (r_count != '0);
    assign pop        = o_wk_valid && i_wk_ready;
    assign o_wk_label = r_lbl[r_rd_ptr];
    assign o_wk_ctl   = r_ctl[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // mask or widen the label to the bitmap's address width
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_lbl[r_wr_ptr] <= LABEL_BITS'(i_in.pixel_label);
            r_ctl[r_wr_ptr] <= in_ctl;
        end
    end

endmodule

[src/wdld_back.sv]
// Back end: seen-label bitmap with epoch marks, saturating counters, window close.
module wdld_back #(
    parameter int LABEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wk_valid,
    output logic                  o_wk_ready,
    input  logic [LABEL_BITS-1:0] i_wk_label,
    input  wdld_pkg::t_work_ctl   i_wk_ctl,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output wdld_pkg::t_job        o_job,
    output wdld_pkg::t_back_stat  o_stat
);

    import wdld_pkg::*;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    t_back_state           r_state, n_state;
    logic [LABEL_BITS-1:0] r_sweep_addr;
    logic [EPOCH_W-1:0]    r_epoch;
    logic                  r_b_valid;
    logic [LABEL_BITS-1:0] r_b_label;
    t_work_ctl             r_b_ctl;
    logic                  r_fwd_valid;
    logic [LABEL_BITS-1:0] r_fwd_label;
    logic [COUNT_W-1:0]    r_distinct;
    logic [COUNT_W-1:0]    r_small;

    logic [EPOCH_W-1:0]    ram_rdata;
    logic                  ram_we;
    logic [LABEL_BITS-1:0] ram_waddr;
    logic [EPOCH_W-1:0]    ram_wdata;
    logic [LABEL_BITS-1:0] ram_raddr;

    logic               sweeping, running;
    logic               b_hit, b_nz, b_new, b_stall, b_fire, wrap_pend, issue;
    logic [COUNT_W-1:0] dist_next, small_next;

    // state outputs
    always_comb begin
        sweeping = (r_state == BK_SWEEP);
        running  = (r_state == BK_RUN);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_SWEEP: begin
                if (r_sweep_addr == '1) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (b_fire && r_b_ctl.last && (r_epoch == EPOCH_MAX)) begin
                    n_state = BK_SWEEP;
                end
            end
            default: n_state = BK_SWEEP;
        endcase
    end

    always_comb begin
        // a label written by the previous beat is not yet visible in the read data
        b_hit     = (ram_rdata == r_epoch) || (r_fwd_valid && (r_fwd_label == r_b_label));
        b_nz      = (r_b_label != '0);
        b_new     = b_nz && !b_hit;
        b_stall   = r_b_valid && r_b_ctl.last && !i_job_ready;
        b_fire    = r_b_valid && !b_stall;
        wrap_pend = r_b_valid && r_b_ctl.last && (r_epoch == EPOCH_MAX);
        o_wk_ready = running && !wrap_pend && (!r_b_valid || b_fire);
        issue     = o_wk_ready && i_wk_valid;

        dist_next  = (b_new && (r_distinct != COUNT_MAX)) ? r_distinct + 1'b1 : r_distinct;
        small_next = (r_b_ctl.is_small && (r_small != COUNT_MAX)) ? r_small + 1'b1 : r_small;

        o_job_valid        = r_b_valid && r_b_ctl.last;
        o_job.distinct_cnt = dist_next;
        o_job.small_cnt    = small_next;
        o_job.quarter      = r_b_ctl.quarter;

        // re-read the held label while stalled so its data stays current
        ram_raddr = b_stall ? r_b_label : i_wk_label;
        ram_we    = sweeping || (b_fire && b_nz);
        ram_waddr = sweeping ? r_sweep_addr : r_b_label;
        ram_wdata = sweeping ? '0 : r_epoch;

        o_stat.sweeping = sweeping;
        o_stat.issue    = issue;
    end

    wdld_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (2 ** LABEL_BITS)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_SWEEP;
            r_sweep_addr <= '0;
            r_epoch      <= EPOCH_ONE;
            r_b_valid    <= 1'b0;
            r_fwd_valid  <= 1'b0;
            r_distinct   <= '0;
            r_small      <= '0;
        end else begin
            r_state     <= n_state;
            r_fwd_valid <= b_fire && b_nz && !r_b_ctl.last;
            if (sweeping) begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
            end
            if (issue) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                if (r_b_ctl.last) begin
                    // close the window: new epoch, counters back to zero
                    r_epoch    <= (r_epoch == EPOCH_MAX) ? EPOCH_ONE : r_epoch + 1'b1;
                    r_distinct <= '0;
                    r_small    <= '0;
                end else begin
                    r_distinct <= dist_next;
                    r_small    <= small_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_label <= r_b_label;
        if (issue) begin
            r_b_label <= i_wk_label;
            r_b_ctl   <= i_wk_ctl;
        end
    end

endmodule

[src/wdld_div.sv]
// Density unit: divide by the window area through a constant reciprocal, result register.
module wdld_div #(
    parameter int WINDOW_SIDE = 70
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  wdld_pkg::t_job i_job,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output wdld_pkg::t_out o_out
);

    import wdld_pkg::*;

    localparam int AREA         = WINDOW_SIDE * WINDOW_SIDE;
    localparam int QUARTER_AREA = AREA / 4;
    localparam int DV_W         = $clog2(AREA + 1);
    localparam int RECIP_W      = DIVIDEND_W + 1;
    // the sum stays below 2^EST_SHIFT, so the estimate is short by at most one
    localparam int EST_SHIFT    = DIVIDEND_W - FRAC_W;
    localparam int PROD_W       = EST_SHIFT + DIVIDEND_W;

    localparam logic [RECIP_W-1:0] RECIP_AREA    =
        RECIP_W'((longint'(1) << DIVIDEND_W) / longint'(AREA));
    localparam logic [RECIP_W-1:0] RECIP_QUARTER =
        RECIP_W'((longint'(1) << DIVIDEND_W) / longint'(QUARTER_AREA));

    t_div_state            r_state, n_state;
    logic [DV_W-1:0]       r_divisor;
    logic [RECIP_W-1:0]    r_recip;
    logic [SUM_W-1:0]      r_sum;
    logic [DIVIDEND_W-1:0] r_qest;
    logic [DIVIDEND_W-1:0] r_qd;
    logic [DENSITY_W-1:0]  r_dens;
    logic [COUNT_W-1:0]    r_distinct;
    logic [COUNT_W-1:0]    r_small;

    logic                  start;
    logic [SUM_W-1:0]      sum;
    logic [PROD_W-1:0]     prod;
    logic [DIVIDEND_W-1:0] num, rem, q_fix;
    logic                  ge;

    always_comb begin
        o_job_ready = (r_state == DV_IDLE);
        o_out_valid = (r_state == DV_DONE);
    end

    always_comb begin
        start = i_job_valid && o_job_ready;
        sum   = {1'b0, i_job.distinct_cnt} + {1'b0, i_job.small_cnt};
        prod  = PROD_W'(r_sum) * PROD_W'(r_recip);
        num   = {r_sum, FRAC_W'(0)};
        rem   = num - r_qd;
        ge    = (rem >= DIVIDEND_W'(r_divisor));
        q_fix = r_qest + DIVIDEND_W'(ge);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE: if (start) n_state = DV_MUL;
            DV_MUL:  n_state = DV_CHK;
            DV_CHK:  n_state = DV_FIX;
            DV_FIX:  n_state = DV_DONE;
            DV_DONE: if (i_out_ready) n_state = DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        o_out.distinct_cells = r_distinct;
        o_out.small_pixels   = r_small;
        o_out.density_q16    = r_dens;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_distinct <= i_job.distinct_cnt;
            r_small    <= i_job.small_cnt;
            r_sum      <= sum;
            r_divisor  <= i_job.quarter ? DV_W'(QUARTER_AREA) : DV_W'(AREA);
            r_recip    <= i_job.quarter ? RECIP_QUARTER : RECIP_AREA;
        end
        // estimate the quotient, then check it against the divisor once
        if (r_state == DV_MUL) begin
            r_qest <= DIVIDEND_W'(prod >> EST_SHIFT);
        end
        if (r_state == DV_CHK) begin
            r_qd <= r_qest * DIVIDEND_W'(r_divisor);
        end
        if (r_state == DV_FIX) begin
            // clamp to the Q4.16 range
            r_dens <= (|q_fix[DIVIDEND_W-1:DENSITY_W]) ? '1 : q_fix[DENSITY_W-1:0];
        end
    end

endmodule

[src/window_distinct_label_density.sv]
// Top level: distinct label and small pixel counts with density over a square window.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------
//  in      | input     | i_in_valid/o_in_ready | t_in: label, stage, centre flag, last
//  out     | output    | o_out_valid/i_out_ready | t_out: distinct, small, density_q16
//
//  Pixels flow at one beat per cycle while the back is not sweeping or stalled,
//  bounded by the read-modify-write of the seen-label RAM (registered read
//  plus a one-beat write forward). A window result passes through the queue and
//  the bitmap stage, then the reciprocal divider's estimate, back-multiply and
//  correct steps; a last pixel that meets a busy divider stalls the back.
//  After reset, and after every 2^EPOCH_W - 1 windows, a sweep clears all
//  2^LABEL_BITS words of the RAM; input beats still queue in the front until it is full.
//  Output beats wait in the divider's result register, untouched by input stalls.
module window_distinct_label_density #(
    parameter int WINDOW_SIDE = wdld_pkg::WINDOW_SIDE_DEF,
    parameter int LABEL_BITS  = wdld_pkg::LABEL_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wdld_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output wdld_pkg::t_out o_out
);

    import wdld_pkg::*;

    // front to back: classified pixel
    logic                  wk_valid, wk_ready;
    logic [LABEL_BITS-1:0] wk_label;
    t_work_ctl             wk_ctl;

    // back to divider: closed window counts
    logic                  job_valid, job_ready;
    t_job                  job;
    t_back_stat            bk_stat;

    // accept, mask the label, flag small pixels, queue
    wdld_front #(
        .LABEL_BITS (LABEL_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_wk_valid (wk_valid),
        .i_wk_ready (wk_ready),
        .o_wk_label (wk_label),
        .o_wk_ctl   (wk_ctl)
    );

    // look up and mark labels, count, close the window on the last pixel
    wdld_back #(
        .LABEL_BITS (LABEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wk_valid  (wk_valid),
        .o_wk_ready  (wk_ready),
        .i_wk_label  (wk_label),
        .i_wk_ctl    (wk_ctl),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job),
        .o_stat      (bk_stat)
    );

    // divide the sum by the full or quarter area, hold the result beat
    wdld_div #(
        .WINDOW_SIDE (WINDOW_SIDE)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // no pixel may enter the bitmap pipeline while the RAM is being cleared
    a_no_issue_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.sweeping |-> !bk_stat.issue)
        else $error("pixel issued during bitmap sweep");

    // a new window is handed over only when no result beat is pending
    a_job_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_valid && job_ready) |-> !o_out_valid)
        else $error("window closed while a result was still pending");

    // once a window is taken the divider is busy and shows no result yet
    a_div_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_valid && job_ready) |=> (!job_ready && !o_out_valid))
        else $error("divider not busy after taking a window");

endmodule
